// ===== hw/rtl/wbs_pkg.sv =====
// ----------------------------------------------------------------------------
// wbs_pkg
// Types and constants shared by the white blob steering block.
// ----------------------------------------------------------------------------
package wbs_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 15;
  localparam int RowCfgW  = 13;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW_PIXELS    = 3'd0,
    CFG_WHITE_LEVEL   = 3'd1,
    CFG_LEFT_PERCENT  = 3'd2,
    CFG_RIGHT_PERCENT = 3'd3,
    CFG_FORWARD_SPEED = 3'd4,
    CFG_TURN_RATE     = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REGION_STOP   = 2'd0,
    REGION_LEFT   = 2'd1,
    REGION_MIDDLE = 2'd2,
    REGION_RIGHT  = 2'd3
  } region_e;

  localparam logic [6:0] PctScale = 7'd100;

  typedef struct packed {
    logic [RowCfgW-1:0] row_pixels;
    logic [7:0]         white_level;
    logic [6:0]         left_percent;
    logic [6:0]         right_percent;
    logic [14:0]        forward_speed;
    logic [14:0]        turn_rate;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } pixel_t;

  typedef struct packed {
    region_e            region;
    logic [14:0]        linear_speed;
    logic signed [15:0] angular_rate;
  } drive_t;

endpackage

// ===== hw/rtl/wbs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// wbs_cfg_regs
// Configuration registers, effective row width and registered section limits.
// ----------------------------------------------------------------------------
module wbs_cfg_regs #(
  parameter int MAX_ROW_PIXELS = 4096
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         cfg_we_i,
  input  logic [wbs_pkg::CfgIdxW-1:0]                  cfg_idx_i,
  input  logic [wbs_pkg::CfgDataW-1:0]                 cfg_data_i,
  output wbs_pkg::cfg_t                                cfg_o,
  output logic [$clog2(MAX_ROW_PIXELS+1)-1:0]          width_o,
  output logic [$clog2(MAX_ROW_PIXELS)+7:0]            lim_left_o,
  output logic [$clog2(MAX_ROW_PIXELS)+7:0]            lim_right_o
);
  import wbs_pkg::*;

  localparam int WW = $clog2(MAX_ROW_PIXELS + 1);
  localparam int MW = $clog2(MAX_ROW_PIXELS) + 8;
  localparam int EW = (WW > RowCfgW) ? WW : RowCfgW;

  cfg_t            cfg_q;
  logic [EW-1:0]   rp_ext;
  logic [EW-1:0]   w_ext;
  logic [MW-1:0]   lim_left_q, lim_left_d;
  logic [MW-1:0]   lim_right_q, lim_right_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_pixels    <= RowCfgW'(800);
      cfg_q.white_level   <= 8'd255;
      cfg_q.left_percent  <= 7'd33;
      cfg_q.right_percent <= 7'd66;
      cfg_q.forward_speed <= 15'd819;
      cfg_q.turn_rate     <= 15'd2048;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ROW_PIXELS:    cfg_q.row_pixels    <= cfg_data_i[RowCfgW-1:0];
        CFG_WHITE_LEVEL:   cfg_q.white_level   <= cfg_data_i[7:0];
        CFG_LEFT_PERCENT:  cfg_q.left_percent  <= cfg_data_i[6:0];
        CFG_RIGHT_PERCENT: cfg_q.right_percent <= cfg_data_i[6:0];
        CFG_FORWARD_SPEED: cfg_q.forward_speed <= cfg_data_i[14:0];
        CFG_TURN_RATE:     cfg_q.turn_rate     <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // clamp row width to 1 .. MAX_ROW_PIXELS
  always_comb begin
    rp_ext = EW'(cfg_q.row_pixels);
    if (rp_ext == '0) begin
      w_ext = EW'(1);
    end else if (rp_ext > EW'(MAX_ROW_PIXELS)) begin
      w_ext = EW'(MAX_ROW_PIXELS);
    end else begin
      w_ext = rp_ext;
    end
  end

  assign width_o = w_ext[WW-1:0];

  assign lim_left_d  = MW'({cfg_q.left_percent, 1'b0}) * MW'(width_o);
  assign lim_right_d = MW'({cfg_q.right_percent, 1'b0}) * MW'(width_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_left_q  <= '0;
      lim_right_q <= '0;
    end else begin
      lim_left_q  <= lim_left_d;
      lim_right_q <= lim_right_d;
    end
  end

  assign cfg_o       = cfg_q;
  assign lim_left_o  = lim_left_q;
  assign lim_right_o = lim_right_q;

endmodule

// ===== hw/rtl/wbs_scan.sv =====
// ----------------------------------------------------------------------------
// wbs_scan
// Input skid stage, pixel register and run tracker; snapshots the run at
// frame end.
// ----------------------------------------------------------------------------
module wbs_scan #(
  parameter int MAX_ROW_PIXELS = 4096
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  wbs_pkg::pixel_t                         in_data_i,
  input  logic [7:0]                              white_level_i,
  input  logic [$clog2(MAX_ROW_PIXELS+1)-1:0]     width_i,
  output logic                                    snap_valid_o,
  output logic                                    snap_found_o,
  output logic [$clog2(MAX_ROW_PIXELS)-1:0]       snap_start_o,
  output logic [$clog2(MAX_ROW_PIXELS):0]         snap_end_o
);
  import wbs_pkg::*;

  localparam int CW = $clog2(MAX_ROW_PIXELS);
  localparam int WW = $clog2(MAX_ROW_PIXELS + 1);

  logic          skid_valid_q;
  pixel_t        skid_q;
  logic          head_valid;
  pixel_t        head;

  logic          a_valid_q;
  pixel_t        a_q;

  logic [CW-1:0] column_q, column_d;
  logic          found_q, found_d;
  logic          in_run_q, in_run_d;
  logic [CW-1:0] start_q, start_d;
  logic [CW:0]   end_q, end_d;
  logic          snap_found;
  logic [CW-1:0] snap_start;
  logic [CW:0]   snap_end;

  logic          b_valid_q;
  logic          b_found_q;
  logic [CW-1:0] b_start_q;
  logic [CW:0]   b_end_q;

  logic          white;
  logic          row_last;

  assign in_stall_o = skid_valid_q;
  assign head_valid = skid_valid_q | in_valid_i;
  assign head       = skid_valid_q ? skid_q : in_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (en_i) begin
      skid_valid_q <= 1'b0;
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en_i && in_valid_i && !skid_valid_q) begin
      skid_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= head_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= head;
    end
  end

  assign white = (a_q.red == white_level_i) && (a_q.green == white_level_i) &&
                 (a_q.blue == white_level_i);
  assign row_last = (WW'(column_q) + WW'(1)) >= width_i;

  always_comb begin
    column_d   = column_q;
    found_d    = found_q;
    in_run_d   = in_run_q;
    start_d    = start_q;
    end_d      = end_q;
    if (a_valid_q && !found_q) begin
      if (in_run_q) begin
        if (!white) begin
          end_d    = {1'b0, column_q};
          found_d  = 1'b1;
          in_run_d = 1'b0;
        end
      end else if (white) begin
        in_run_d = 1'b1;
        start_d  = column_q;
      end
      if (in_run_d && (row_last || a_q.frame_end)) begin
        end_d    = (CW+1)'(column_q) + (CW+1)'(1);
        found_d  = 1'b1;
        in_run_d = 1'b0;
      end
    end
    snap_found = found_d;
    snap_start = start_d;
    snap_end   = end_d;
    if (a_valid_q) begin
      if (a_q.frame_end) begin
        column_d = '0;
        found_d  = 1'b0;
        in_run_d = 1'b0;
        start_d  = '0;
        end_d    = '0;
      end else if (row_last) begin
        column_d = '0;
      end else begin
        column_d = column_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q  <= '0;
      found_q   <= 1'b0;
      in_run_q  <= 1'b0;
      start_q   <= '0;
      end_q     <= '0;
      b_valid_q <= 1'b0;
    end else if (en_i) begin
      column_q  <= column_d;
      found_q   <= found_d;
      in_run_q  <= in_run_d;
      start_q   <= start_d;
      end_q     <= end_d;
      b_valid_q <= a_valid_q & a_q.frame_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_found_q <= snap_found;
      b_start_q <= snap_start;
      b_end_q   <= snap_end;
    end
  end

  assign snap_valid_o = b_valid_q;
  assign snap_found_o = b_found_q;
  assign snap_start_o = b_start_q;
  assign snap_end_o   = b_end_q;

endmodule

// ===== hw/rtl/wbs_classify.sv =====
// ----------------------------------------------------------------------------
// wbs_classify
// Midpoint scaling, section compare against the limits and the result
// register with the last emitted section.
// ----------------------------------------------------------------------------
module wbs_classify #(
  parameter int MAX_ROW_PIXELS = 4096
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  output logic                                  en_o,
  input  logic                                  snap_valid_i,
  input  logic                                  snap_found_i,
  input  logic [$clog2(MAX_ROW_PIXELS)-1:0]     snap_start_i,
  input  logic [$clog2(MAX_ROW_PIXELS):0]       snap_end_i,
  input  logic [$clog2(MAX_ROW_PIXELS)+7:0]     lim_left_i,
  input  logic [$clog2(MAX_ROW_PIXELS)+7:0]     lim_right_i,
  input  logic [14:0]                           forward_speed_i,
  input  logic [14:0]                           turn_rate_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output wbs_pkg::drive_t                       out_data_o
);
  import wbs_pkg::*;

  localparam int CW = $clog2(MAX_ROW_PIXELS);
  localparam int MW = CW + 8;

  logic          en;
  logic [CW:0]   sum;
  logic [MW-1:0] mid_d;
  logic          c_valid_q;
  logic          c_found_q;
  logic [MW-1:0] mid_q;
  region_e       region;
  region_e       last_region_q;
  logic          out_valid_q;
  drive_t        out_q;
  logic          emit;

  assign en   = !out_valid_q || !out_stall_i;
  assign en_o = en;

  assign sum   = (CW+1)'(snap_start_i) + snap_end_i;
  assign mid_d = MW'(sum) * MW'(PctScale);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en) begin
      c_valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_found_q <= snap_found_i;
      mid_q     <= mid_d;
    end
  end

  always_comb begin
    if (!c_found_q) begin
      region = REGION_STOP;
    end else if (mid_q < lim_left_i) begin
      region = REGION_LEFT;
    end else if (mid_q > lim_right_i) begin
      region = REGION_RIGHT;
    end else begin
      region = REGION_MIDDLE;
    end
  end

  assign emit = c_valid_q && (region != last_region_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      last_region_q <= REGION_STOP;
    end else if (en) begin
      out_valid_q <= emit;
      if (c_valid_q) begin
        last_region_q <= region;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && emit) begin
      out_q.region       <= region;
      out_q.linear_speed <= (region == REGION_STOP) ? 15'd0 : forward_speed_i;
      case (region)
        REGION_LEFT:  out_q.angular_rate <= signed'({1'b0, turn_rate_i});
        REGION_RIGHT: out_q.angular_rate <= signed'(16'd0 - {1'b0, turn_rate_i});
        default:      out_q.angular_rate <= '0;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/white_blob_steering.sv =====
// ----------------------------------------------------------------------------
// white_blob_steering
// Finds the first white pixel run of a frame and issues a drive command
// when the blob's section (stop, left, middle, right) changes.
//
//   port group   dir  handshake              payload
//   in_*         in   in_valid_i/in_stall_o  wbs_pkg::pixel_t
//   out_*        out  out_valid_o/out_stall_i wbs_pkg::drive_t
//   cfg_*        in   cfg_we_i               cfg_idx_i, cfg_data_i
//
// One pixel is taken every cycle while the pipe is not frozen; a command
// for a frame passes from its frame-end pixel through the pixel register,
// the run snapshot, the midpoint product register and the result register.
// Reset clears scan state, the last section (stop) and loads register
// defaults. An output stall with out_valid_o high freezes the pipe; a pixel
// then fills the one-entry input skid, raising in_stall_o the next cycle.
// ----------------------------------------------------------------------------
module white_blob_steering #(
  parameter int MAX_ROW_PIXELS = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  wbs_pkg::pixel_t                in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output wbs_pkg::drive_t                out_data_o,
  input  logic                           cfg_we_i,
  input  logic [wbs_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [wbs_pkg::CfgDataW-1:0]   cfg_data_i
);
  import wbs_pkg::*;

  localparam int CW = $clog2(MAX_ROW_PIXELS);
  localparam int WW = $clog2(MAX_ROW_PIXELS + 1);
  localparam int MW = CW + 8;

  cfg_t          cfg;
  logic [WW-1:0] width;
  logic [MW-1:0] lim_left;
  logic [MW-1:0] lim_right;
  logic          en;
  logic          snap_valid;
  logic          snap_found;
  logic [CW-1:0] snap_start;
  logic [CW:0]   snap_end;

  wbs_cfg_regs #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg),
    .width_o    (width),
    .lim_left_o (lim_left),
    .lim_right_o(lim_right)
  );

  wbs_scan #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .white_level_i(cfg.white_level),
    .width_i      (width),
    .snap_valid_o (snap_valid),
    .snap_found_o (snap_found),
    .snap_start_o (snap_start),
    .snap_end_o   (snap_end)
  );

  wbs_classify #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
  ) u_classify (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_o           (en),
    .snap_valid_i   (snap_valid),
    .snap_found_i   (snap_found),
    .snap_start_i   (snap_start),
    .snap_end_i     (snap_end),
    .lim_left_i     (lim_left),
    .lim_right_i    (lim_right),
    .forward_speed_i(cfg.forward_speed),
    .turn_rate_i    (cfg.turn_rate),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_data_o     (out_data_o)
  );

`ifndef SYNTH
  a_skid_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input skid filled without an output stall");

  a_stop_no_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.region == REGION_STOP) |-> out_data_o.linear_speed == '0)
    else $error("stop command carries a linear speed");

  a_straight_no_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.region == REGION_STOP ||
                     out_data_o.region == REGION_MIDDLE)) |-> out_data_o.angular_rate == '0)
    else $error("straight or stop command carries a turn rate");
`endif

endmodule
